FILE: rtl/iff_pkg.sv
// ----------------------------------------------------------------------------
// Integer field formatter package
// Shared constants, codes, the classified request type and small helper
// functions for the formatter front end, request queue and back end.
// ----------------------------------------------------------------------------
package iff_pkg;

    localparam int POINTER_BYTES = 8;
    localparam int GROUP_ENTRIES = 4;
    localparam int MAX_WIDTH     = 63;

    localparam int VALUE_W    = 64;
    localparam int CONV_W     = 4;
    localparam int SIZE_W     = 2;
    localparam int WIDTH_W    = 6;
    localparam int CHAR_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int BYTES_W    = 4;

    // Longest body: twenty digits, nineteen separators (or a sign).
    localparam int BODY_MAX = 40;
    localparam int BLEN_W   = 6;

    localparam int BCD_W        = 80;
    localparam int DABBLE_BITS  = 4;
    localparam int DABBLE_STEPS = VALUE_W / DABBLE_BITS;
    localparam int STEP_W       = $clog2(DABBLE_STEPS);

    localparam int GROUP_SLOTS = (GROUP_ENTRIES < 4) ? GROUP_ENTRIES : 4;
    localparam int GI_W        = 2;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam logic [CONV_W-1:0] CONV_SDEC = 4'd0;
    localparam logic [CONV_W-1:0] CONV_UDEC = 4'd1;
    localparam logic [CONV_W-1:0] CONV_SGRP = 4'd2;
    localparam logic [CONV_W-1:0] CONV_UGRP = 4'd3;
    localparam logic [CONV_W-1:0] CONV_HEXU = 4'd4;
    localparam logic [CONV_W-1:0] CONV_HEXL = 4'd5;
    localparam logic [CONV_W-1:0] CONV_PTRL = 4'd6;
    localparam logic [CONV_W-1:0] CONV_PTRU = 4'd7;
    localparam logic [CONV_W-1:0] CONV_CHAR = 4'd8;

    localparam logic [SIZE_W-1:0] SIZE_4B = 2'd1;
    localparam logic [SIZE_W-1:0] SIZE_8B = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_SIZES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_SEPS  = 2'd1;

    localparam logic [CFG_DATA_W-1:0] GROUP_SIZES_RST = 32'd255;
    localparam logic [CFG_DATA_W-1:0] GROUP_SEPS_RST  = 32'd44;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_UPPER = 8'h41;
    localparam logic [CHAR_W-1:0] CH_LOWER = 8'h61;

    typedef enum logic [1:0] {
        K_DEC  = 2'd0,
        K_HEX  = 2'd1,
        K_CHAR = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [VALUE_W-1:0]   mag;
        logic                 minus;
        logic                 grouped;
        logic                 upper;
        logic                 fill_zero;
        logic                 left;
        logic [WIDTH_W-1:0]   width;
    } t_desc;

    function automatic logic [VALUE_W-1:0] size_mask(input logic [BYTES_W-1:0] bytes);
        logic [VALUE_W-1:0] m;
        case (bytes)
            4'd8:    m = {VALUE_W{1'b1}};
            4'd4:    m = {32'd0, 32'hFFFF_FFFF};
            default: m = {48'd0, 16'hFFFF};
        endcase
        return m;
    endfunction

    // Byte idx of a group register; entries past the usable slots read as zero.
    function automatic logic [CHAR_W-1:0] reg_byte(input logic [CFG_DATA_W-1:0] r,
                                                   input logic [GI_W:0] idx);
        logic [CFG_DATA_W-1:0] sh;
        sh = r >> {idx, 3'b000};
        if (int'(idx) >= GROUP_SLOTS) begin
            return '0;
        end
        return sh[CHAR_W-1:0];
    endfunction

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d, input logic upper);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {4'd0, d};
        end else if (upper) begin
            c = CH_UPPER + {4'd0, d - 4'd10};
        end else begin
            c = CH_LOWER + {4'd0, d - 4'd10};
        end
        return c;
    endfunction

endpackage

FILE: rtl/iff_front.sv
// ----------------------------------------------------------------------------
// Formatter front end
// Accepts requests and classifies them: selects the argument size, takes the
// magnitude and sign, and settles fill, alignment and effective width.
// ----------------------------------------------------------------------------
module iff_front (
    input  logic                          push,
    output logic                          full,
    input  logic [iff_pkg::VALUE_W-1:0]   i_value,
    input  logic [iff_pkg::CONV_W-1:0]    i_conversion,
    input  logic [iff_pkg::SIZE_W-1:0]    i_size_code,
    input  logic [iff_pkg::WIDTH_W-1:0]   i_field_width,
    input  logic                          i_zero_fill,
    input  logic                          i_left_align,
    input  logic                          i_q_full,
    output logic                          o_q_wr,
    output iff_pkg::t_desc                o_desc
);
    import iff_pkg::*;

    logic [BYTES_W-1:0] bytes;
    logic [VALUE_W-1:0] mask;
    logic [VALUE_W-1:0] t;
    logic [VALUE_W-1:0] topbit;
    logic [WIDTH_W-1:0] wsat;

    assign full   = i_q_full;
    assign o_q_wr = push && !i_q_full;

    always_comb begin
        bytes  = (i_size_code == SIZE_4B) ? 4'd4 : (i_size_code == SIZE_8B) ? 4'd8 : 4'd2;
        wsat   = (int'(i_field_width) > MAX_WIDTH) ? WIDTH_W'(MAX_WIDTH) : i_field_width;
        mask   = size_mask(bytes);
        t      = i_value & mask;
        topbit = (mask >> 1) + 64'd1;

        o_desc           = '0;
        o_desc.kind      = K_CHAR;
        o_desc.mag       = {56'd0, i_value[CHAR_W-1:0]};
        o_desc.fill_zero = i_zero_fill;
        o_desc.left      = i_left_align;
        o_desc.width     = wsat;

        if (i_conversion <= CONV_UGRP) begin
            o_desc.kind    = K_DEC;
            o_desc.grouped = (i_conversion == CONV_SGRP) || (i_conversion == CONV_UGRP);
            o_desc.minus   = ((i_conversion == CONV_SDEC) || (i_conversion == CONV_SGRP))
                             && ((t & topbit) != '0);
            o_desc.mag     = o_desc.minus ? ((64'd0 - t) & mask) : t;
        end else if (i_conversion <= CONV_PTRU) begin
            if (i_conversion >= CONV_PTRL) begin
                o_desc.fill_zero = 1'b1;
                o_desc.width     = WIDTH_W'(2 * POINTER_BYTES);
                if (int'(bytes) < POINTER_BYTES) begin
                    bytes = BYTES_W'(POINTER_BYTES);
                end
            end
            o_desc.kind  = K_HEX;
            o_desc.upper = !((i_conversion == CONV_HEXL) || (i_conversion == CONV_PTRL));
            o_desc.mag   = i_value & size_mask(bytes);
        end else if (i_conversion != CONV_CHAR) begin
            // Literal and unused codes: one character, never padded.
            o_desc.width = WIDTH_W'(1);
        end
    end

endmodule

FILE: rtl/iff_queue.sv
// ----------------------------------------------------------------------------
// Formatter request queue
// Short queue of classified requests between the front end and the back end.
// ----------------------------------------------------------------------------
module iff_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  iff_pkg::t_desc  i_wr_data,
    output logic            o_full,
    input  logic            i_rd,
    output iff_pkg::t_desc  o_rd_data,
    output logic            o_empty
);
    import iff_pkg::*;

    t_desc                r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count,  n_count;

    assign o_full    = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr) begin
            n_wr_ptr = (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_rd) begin
            n_rd_ptr = (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr && i_rd) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_slot[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

FILE: rtl/iff_back.sv
// ----------------------------------------------------------------------------
// Formatter back end
// Converts one classified request into its body (binary to BCD, digit
// grouping, sign, hex digits), then streams padding and body through an
// output register, one character per cycle while results are popped.
// ----------------------------------------------------------------------------
module iff_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_empty,
    output logic                             o_q_rd,
    input  iff_pkg::t_desc                   i_desc,
    input  logic [iff_pkg::CFG_DATA_W-1:0]   i_group_sizes,
    input  logic [iff_pkg::CFG_DATA_W-1:0]   i_group_seps,
    input  logic                             i_pop,
    output logic                             o_empty,
    output logic [iff_pkg::CHAR_W-1:0]       o_character,
    output logic                             o_last
);
    import iff_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DABBLE = 7'b0000010,
        S_BUILD  = 7'b0000100,
        S_SEP    = 7'b0001000,
        S_SIGN   = 7'b0010000,
        S_SIZE   = 7'b0100000,
        S_EMIT   = 7'b1000000
    } t_state;

    t_state                r_state, n_state;
    t_kind                 r_kind, n_kind;
    logic [VALUE_W-1:0]    r_val, n_val;
    logic [BCD_W-1:0]      r_bcd, n_bcd;
    logic                  r_minus, n_minus;
    logic                  r_grouped, n_grouped;
    logic                  r_upper, n_upper;
    logic                  r_fill_zero, n_fill_zero;
    logic                  r_left, n_left;
    logic [WIDTH_W-1:0]    r_width, n_width;
    logic [STEP_W-1:0]     r_step, n_step;
    logic [CHAR_W-1:0]     r_gsize, n_gsize;
    logic [GI_W-1:0]       r_gi, n_gi;
    logic [CHAR_W-1:0]     r_sep_char, n_sep_char;
    logic [CHAR_W-1:0]     r_body [BODY_MAX];
    logic [CHAR_W-1:0]     n_body [BODY_MAX];
    logic [BLEN_W-1:0]     r_blen, n_blen;
    logic [WIDTH_W-1:0]    r_pad, n_pad;
    logic                  r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]     r_char, n_char;
    logic                  r_last, n_last;

    logic                  push_body;
    logic                  pop_body;
    logic [CHAR_W-1:0]     push_char;
    logic                  more;
    logic                  sep_now;
    logic [CHAR_W-1:0]     gs;
    logic [CHAR_W-1:0]     nx;
    logic [GI_W:0]         gi_ext;
    logic [GI_W:0]         gi_next;
    logic [WIDTH_W:0]      rem;
    logic [CHAR_W-1:0]     fill;
    logic                  slot_free;

    // Shift-add-3 conversion, DABBLE_BITS binary bits per call.
    function automatic logic [BCD_W+VALUE_W-1:0] dabble_steps(
        input logic [BCD_W+VALUE_W-1:0] acc);
        logic [BCD_W+VALUE_W-1:0] a;
        a = acc;
        for (int k = 0; k < DABBLE_BITS; k++) begin
            for (int j = 0; j < BCD_W / 4; j++) begin
                if (a[VALUE_W + 4*j +: 4] >= 4'd5) begin
                    a[VALUE_W + 4*j +: 4] = a[VALUE_W + 4*j +: 4] + 4'd3;
                end
            end
            a = a << 1;
        end
        return a;
    endfunction

    assign o_empty     = !r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_val       = r_val;
        n_bcd       = r_bcd;
        n_minus     = r_minus;
        n_grouped   = r_grouped;
        n_upper     = r_upper;
        n_fill_zero = r_fill_zero;
        n_left      = r_left;
        n_width     = r_width;
        n_step      = r_step;
        n_gsize     = r_gsize;
        n_gi        = r_gi;
        n_sep_char  = r_sep_char;
        n_blen      = r_blen;
        n_pad       = r_pad;
        n_char      = r_char;
        n_last      = r_last;
        o_q_rd      = 1'b0;
        push_body   = 1'b0;
        pop_body    = 1'b0;
        push_char   = '0;
        sep_now     = 1'b0;
        more        = (r_bcd[BCD_W-1:4] != '0);
        gs          = r_gsize - 8'd1;
        gi_ext      = {1'b0, r_gi};
        gi_next     = gi_ext + 1'b1;
        nx          = reg_byte(i_group_sizes, gi_next);
        rem         = {1'b0, r_pad} + {1'b0, r_blen};
        fill        = r_fill_zero ? CH_ZERO : CH_SPACE;
        slot_free   = !r_out_valid || i_pop;
        n_out_valid = r_out_valid && !i_pop;

        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_rd      = 1'b1;
                    n_kind      = i_desc.kind;
                    n_val       = i_desc.mag;
                    n_minus     = i_desc.minus;
                    n_grouped   = i_desc.grouped;
                    n_upper     = i_desc.upper;
                    n_fill_zero = i_desc.fill_zero;
                    n_left      = i_desc.left;
                    n_width     = i_desc.width;
                    n_bcd       = '0;
                    n_step      = '0;
                    n_gsize     = reg_byte(i_group_sizes, '0);
                    n_gi        = '0;
                    n_blen      = '0;
                    n_state     = (i_desc.kind == K_DEC) ? S_DABBLE : S_BUILD;
                end
            end
            S_DABBLE: begin
                {n_bcd, n_val} = dabble_steps({r_bcd, r_val});
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(DABBLE_STEPS - 1)) begin
                    n_state = S_BUILD;
                end
            end
            S_BUILD: begin
                case (r_kind)
                    K_DEC: begin
                        push_body = 1'b1;
                        push_char = CH_ZERO + {4'd0, r_bcd[3:0]};
                        n_bcd     = r_bcd >> 4;
                        if (r_grouped) begin
                            n_gsize = gs;
                            if (gs == '0 && more) begin
                                // Group is full: queue its separator and move on
                                // to the next size, or repeat this one if zero.
                                sep_now    = 1'b1;
                                n_sep_char = reg_byte(i_group_seps, gi_ext);
                                if (nx == '0) begin
                                    n_gsize = reg_byte(i_group_sizes, gi_ext);
                                end else begin
                                    n_gsize = nx;
                                    n_gi    = r_gi + 1'b1;
                                end
                            end
                        end
                        if (sep_now) begin
                            n_state = S_SEP;
                        end else if (!more) begin
                            n_state = r_minus ? S_SIGN : S_SIZE;
                        end
                    end
                    K_HEX: begin
                        push_body = 1'b1;
                        push_char = hex_char(r_val[3:0], r_upper);
                        n_val     = r_val >> 4;
                        if (r_val[VALUE_W-1:4] == '0) begin
                            n_state = S_SIZE;
                        end
                    end
                    default: begin
                        push_body = 1'b1;
                        push_char = r_val[CHAR_W-1:0];
                        n_state   = S_SIZE;
                    end
                endcase
            end
            S_SEP: begin
                push_body = 1'b1;
                push_char = r_sep_char;
                n_state   = S_BUILD;
            end
            S_SIGN: begin
                push_body = 1'b1;
                push_char = CH_MINUS;
                n_state   = S_SIZE;
            end
            S_SIZE: begin
                n_pad   = (r_width > r_blen) ? r_width - r_blen : '0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_last      = (rem == 7'd1);
                    if (!r_left && r_pad != '0) begin
                        n_char = fill;
                        n_pad  = r_pad - 1'b1;
                    end else if (r_blen != '0) begin
                        n_char   = r_body[0];
                        pop_body = 1'b1;
                        n_blen   = r_blen - 1'b1;
                    end else begin
                        n_char = fill;
                        n_pad  = r_pad - 1'b1;
                    end
                    if (rem == 7'd1) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Body is built least significant first, so new characters go in at
        // the head and the finished body leaves from the head.
        n_body = r_body;
        if (push_body) begin
            n_blen    = r_blen + 1'b1;
            n_body[0] = push_char;
            for (int i = 1; i < BODY_MAX; i++) begin
                n_body[i] = r_body[i-1];
            end
        end else if (pop_body) begin
            for (int i = 0; i < BODY_MAX - 1; i++) begin
                n_body[i] = r_body[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_val       <= n_val;
        r_bcd       <= n_bcd;
        r_minus     <= n_minus;
        r_grouped   <= n_grouped;
        r_upper     <= n_upper;
        r_fill_zero <= n_fill_zero;
        r_left      <= n_left;
        r_width     <= n_width;
        r_step      <= n_step;
        r_gsize     <= n_gsize;
        r_gi        <= n_gi;
        r_sep_char  <= n_sep_char;
        r_body      <= n_body;
        r_blen      <= n_blen;
        r_pad       <= n_pad;
        r_char      <= n_char;
        r_last      <= n_last;
    end

endmodule

FILE: rtl/integer_field_formatter_unit.sv
// ----------------------------------------------------------------------------
// Integer field formatter
// Formats one parsed integer conversion into padded ASCII characters, one
// character per result with the final one marked.
//
//   Channel  | Handshake                        | Payload
//   ---------+----------------------------------+-------------------------------
//   request  | push / full                      | value, conversion, size_code,
//            |                                  | field_width, zero_fill, align
//   result   | empty / pop                      | character, last
//   config   | i_cfg_valid / o_cfg_ready (=1)   | i_cfg_index, i_cfg_data
//
// A request waits in a two-entry queue; the back end takes one at a time.
// Decimal requests go through a binary to BCD converter first; hex, pointer
// and char requests build their body directly. Padding and body (digits,
// separators, sign) then leave one character at a time through the output
// register. A stalled result holds the output; the front end keeps taking
// requests until the queue is full. Synchronous reset empties all.
// ----------------------------------------------------------------------------
module integer_field_formatter_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [iff_pkg::VALUE_W-1:0]      i_value,
    input  logic [iff_pkg::CONV_W-1:0]       i_conversion,
    input  logic [iff_pkg::SIZE_W-1:0]       i_size_code,
    input  logic [iff_pkg::WIDTH_W-1:0]      i_field_width,
    input  logic                             i_zero_fill,
    input  logic                             i_left_align,
    output logic                             empty,
    input  logic                             pop,
    output logic [iff_pkg::CHAR_W-1:0]       o_character,
    output logic                             o_last,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [iff_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [iff_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import iff_pkg::*;

    logic [CFG_DATA_W-1:0] r_group_sizes;
    logic [CFG_DATA_W-1:0] r_group_seps;
    logic                  q_full;
    logic                  q_empty;
    logic                  q_wr;
    logic                  q_rd;
    t_desc                 wr_desc;
    t_desc                 rd_desc;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_sizes <= GROUP_SIZES_RST;
            r_group_seps  <= GROUP_SEPS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_GROUP_SIZES: r_group_sizes <= i_cfg_data;
                CFG_GROUP_SEPS:  r_group_seps  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    iff_front u_front (
        .push          (push),
        .full          (full),
        .i_value       (i_value),
        .i_conversion  (i_conversion),
        .i_size_code   (i_size_code),
        .i_field_width (i_field_width),
        .i_zero_fill   (i_zero_fill),
        .i_left_align  (i_left_align),
        .i_q_full      (q_full),
        .o_q_wr        (q_wr),
        .o_desc        (wr_desc)
    );

    iff_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (q_wr),
        .i_wr_data (wr_desc),
        .o_full    (q_full),
        .i_rd      (q_rd),
        .o_rd_data (rd_desc),
        .o_empty   (q_empty)
    );

    iff_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .o_q_rd        (q_rd),
        .i_desc        (rd_desc),
        .i_group_sizes (r_group_sizes),
        .i_group_seps  (r_group_seps),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_character   (o_character),
        .o_last        (o_last)
    );

endmodule

FILE: rtl/iff_checker.sv
// ----------------------------------------------------------------------------
// Integer field formatter checker
// Port-level checks of the request and result queues, bound to the top level.
// ----------------------------------------------------------------------------
module iff_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         push,
    input logic                         full,
    input logic                         empty,
    input logic                         pop,
    input logic [iff_pkg::CHAR_W-1:0]   o_character,
    input logic                         o_last
);
    import iff_pkg::*;

    // Reset leaves no result pending and room for a request.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("result or request queue not cleared by reset");

    // A waiting result stays put until it is taken.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_character) && $stable(o_last))
        else $error("pending result changed or vanished without pop");

    // A result leaves only when it is popped.
    a_empty_by_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(empty) |-> $past(pop) || !$past(i_rst_n))
        else $error("result dropped without pop");

    // The request queue fills only on a push.
    a_full_by_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push))
        else $error("request queue became full without a push");

endmodule

bind integer_field_formatter_unit iff_checker u_iff_checker (.*);
